// ----- hdl/tlbr_pkg.sv -----
package tlbr_pkg;

  localparam int DEF_TLB_ENTRIES = 4;
  localparam int DEF_VPAGE_BITS  = 20;
  localparam int DEF_PFRAME_BITS = 16;

  localparam int SLOT_W  = 2;
  localparam int COUNT_W = 32;

  localparam logic KIND_REFILL = 1'b0;
  localparam logic KIND_ACCESS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVICT,
    ST_SCAN
  } state_t;

endpackage

// ----- hdl/tlbr_req_if.sv -----
interface tlbr_req_if
  import tlbr_pkg::*;
#(
  parameter int VPAGE_BITS  = DEF_VPAGE_BITS,
  parameter int PFRAME_BITS = DEF_PFRAME_BITS
);
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [VPAGE_BITS-1:0]  virtual_page;
  logic [PFRAME_BITS-1:0] physical_page;
  logic                   entry_read_only;
  logic                   entry_use;
  logic                   entry_dirty;
  logic                   access_write;

  modport source (
    output valid, kind, virtual_page, physical_page, entry_read_only, entry_use,
           entry_dirty, access_write,
    input  ready
  );

  modport sink (
    input  valid, kind, virtual_page, physical_page, entry_read_only, entry_use,
           entry_dirty, access_write,
    output ready
  );
endinterface

// ----- hdl/tlbr_rsp_if.sv -----
interface tlbr_rsp_if
  import tlbr_pkg::*;
#(
  parameter int VPAGE_BITS  = DEF_VPAGE_BITS,
  parameter int PFRAME_BITS = DEF_PFRAME_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SLOT_W-1:0]      slot;
  logic                   filled_invalid;
  logic                   writeback_valid;
  logic [VPAGE_BITS-1:0]  writeback_page;
  logic                   writeback_use;
  logic                   writeback_dirty;
  logic                   hit;
  logic [PFRAME_BITS-1:0] hit_frame;
  logic                   write_fault;
  logic [COUNT_W-1:0]     miss_count;
  logic [COUNT_W-1:0]     invalid_fill_count;
  logic [COUNT_W-1:0]     replace_count;

  modport source (
    output valid, slot, filled_invalid, writeback_valid, writeback_page, writeback_use,
           writeback_dirty, hit, hit_frame, write_fault, miss_count, invalid_fill_count,
           replace_count,
    input  ready
  );

  modport sink (
    input  valid, slot, filled_invalid, writeback_valid, writeback_page, writeback_use,
           writeback_dirty, hit, hit_frame, write_fault, miss_count, invalid_fill_count,
           replace_count,
    output ready
  );
endinterface

// ----- hdl/tlbr_victim_sel.sv -----
module tlbr_victim_sel
  import tlbr_pkg::*;
#(
  parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
  parameter int IDX_W       = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1
) (
  input  logic [TLB_ENTRIES-1:0] slot_valid,
  output logic                   free_found,
  output logic [IDX_W-1:0]       free_idx
);

  // lowest invalid slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

endmodule

// ----- hdl/tlb_refill_replacement.sv -----
// Fully associative TLB of TLB_ENTRIES slots; page, frame and flags sit in one
// synchronous single-read-port RAM, valid bits in flops. A refill into a free
// slot (lowest invalid first) is installed and its response loaded when it is
// accepted; a refill that evicts the round-robin victim first reads the victim,
// then reports its write-back and installs. An access walks the RAM one slot
// per cycle from slot 0 and stops at the first valid match or after the last
// slot; a hit updates use/dirty as it loads its response. One word is in
// flight at a time; a finished response sits in an output register and the
// next word is taken while it is being consumed.
module tlb_refill_replacement
  import tlbr_pkg::*;
#(
  parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
  parameter int VPAGE_BITS  = DEF_VPAGE_BITS,
  parameter int PFRAME_BITS = DEF_PFRAME_BITS
) (
  input  logic      clk,
  input  logic      rst,
  tlbr_req_if.sink  req,
  tlbr_rsp_if.source rsp
);

  localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int ENT_W = VPAGE_BITS + PFRAME_BITS + 3;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

  state_t state, state_next;

  logic [TLB_ENTRIES-1:0] slot_valid;
  logic [IDX_W-1:0]       cursor;
  logic [COUNT_W-1:0]     refill_total, empty_fill_total, eviction_total;

  logic [ENT_W-1:0]       cur_ent;
  logic                   cur_write;
  logic [IDX_W-1:0]       scan_idx, scan_idx_next;

  logic [ENT_W-1:0] ent_mem [TLB_ENTRIES];
  logic [ENT_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr, mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic             mem_we;

  logic                   res_valid;
  logic [SLOT_W-1:0]      res_slot, res_slot_next;
  logic                   res_filled, res_filled_next;
  logic                   res_wb_valid, res_wb_valid_next;
  logic [VPAGE_BITS-1:0]  res_wb_page, res_wb_page_next;
  logic                   res_wb_use, res_wb_use_next;
  logic                   res_wb_dirty, res_wb_dirty_next;
  logic                   res_hit, res_hit_next;
  logic [PFRAME_BITS-1:0] res_frame, res_frame_next;
  logic                   res_fault, res_fault_next;
  logic                   res_load;

  logic             accept, latch_item;
  logic             inc_refill, inc_fill, inc_evict, set_valid, adv_cursor;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [ENT_W-1:0] new_ent;

  logic [VPAGE_BITS-1:0]  rd_vpage;
  logic [PFRAME_BITS-1:0] rd_frame;
  logic                   rd_ro, rd_use, rd_dirty, rd_match, new_dirty;
  logic [IDX_W+1:0]       free_ext, scan_ext;

  tlbr_victim_sel #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_victim (
    .slot_valid (slot_valid),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  // entry layout: {vpage, frame, read_only, use, dirty}
  assign new_ent  = {req.virtual_page, req.physical_page, req.entry_read_only,
                     req.entry_use, req.entry_dirty};
  assign rd_vpage = rd_data[ENT_W-1 -: VPAGE_BITS];
  assign rd_frame = rd_data[3 +: PFRAME_BITS];
  assign rd_ro    = rd_data[2];
  assign rd_use   = rd_data[1];
  assign rd_dirty = rd_data[0];
  assign rd_match = slot_valid[scan_idx] && (rd_vpage == cur_ent[ENT_W-1 -: VPAGE_BITS]);
  assign new_dirty = rd_dirty | (cur_write & ~rd_ro);

  assign free_ext = {2'b00, free_idx};
  assign scan_ext = {2'b00, scan_idx};

  assign req.ready = (state == ST_IDLE) && (!res_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  always_comb begin
    state_next        = state;
    scan_idx_next     = scan_idx;
    rd_addr           = scan_idx;
    mem_we            = 1'b0;
    mem_waddr         = scan_idx;
    mem_wdata         = cur_ent;
    latch_item        = 1'b0;
    inc_refill        = 1'b0;
    inc_fill          = 1'b0;
    inc_evict         = 1'b0;
    set_valid         = 1'b0;
    adv_cursor        = 1'b0;
    res_load          = 1'b0;
    res_slot_next     = '0;
    res_filled_next   = 1'b0;
    res_wb_valid_next = 1'b0;
    res_wb_page_next  = '0;
    res_wb_use_next   = 1'b0;
    res_wb_dirty_next = 1'b0;
    res_hit_next      = 1'b0;
    res_frame_next    = '0;
    res_fault_next    = 1'b0;
    case (state)
      ST_IDLE: begin
        rd_addr = (req.kind == KIND_REFILL) ? cursor : '0;
        if (accept) begin
          latch_item = 1'b1;
          if (req.kind == KIND_REFILL) begin
            if (free_found) begin
              mem_we          = 1'b1;
              mem_waddr       = free_idx;
              mem_wdata       = new_ent;
              set_valid       = 1'b1;
              inc_refill      = 1'b1;
              inc_fill        = 1'b1;
              res_load        = 1'b1;
              res_slot_next   = free_ext[SLOT_W-1:0];
              res_filled_next = 1'b1;
            end else begin
              scan_idx_next = cursor;
              state_next    = ST_EVICT;
            end
          end else begin
            scan_idx_next = '0;
            state_next    = ST_SCAN;
          end
        end
      end
      ST_EVICT: begin
        mem_we            = 1'b1;
        set_valid         = 1'b1;
        inc_refill        = 1'b1;
        inc_evict         = 1'b1;
        adv_cursor        = 1'b1;
        res_load          = 1'b1;
        res_slot_next     = scan_ext[SLOT_W-1:0];
        res_wb_valid_next = 1'b1;
        res_wb_page_next  = rd_vpage;
        res_wb_use_next   = rd_use;
        res_wb_dirty_next = rd_dirty;
        state_next        = ST_IDLE;
      end
      ST_SCAN: begin
        if (rd_match) begin
          mem_we         = 1'b1;
          mem_wdata      = {rd_vpage, rd_frame, rd_ro, 1'b1, new_dirty};
          res_load       = 1'b1;
          res_slot_next  = scan_ext[SLOT_W-1:0];
          res_hit_next   = 1'b1;
          res_frame_next = rd_frame;
          res_fault_next = cur_write & rd_ro;
          state_next     = ST_IDLE;
        end else if (scan_idx == LAST_IDX) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
          rd_addr       = scan_idx + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ent_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= ent_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid       <= '0;
      cursor           <= '0;
      refill_total     <= '0;
      empty_fill_total <= '0;
      eviction_total   <= '0;
      res_valid        <= 1'b0;
    end else begin
      if (set_valid) begin
        slot_valid[mem_waddr] <= 1'b1;
      end
      if (adv_cursor) begin
        cursor <= (scan_idx == LAST_IDX) ? '0 : scan_idx + 1'b1;
      end
      if (inc_refill) begin
        refill_total <= refill_total + 1'b1;
      end
      if (inc_fill) begin
        empty_fill_total <= empty_fill_total + 1'b1;
      end
      if (inc_evict) begin
        eviction_total <= eviction_total + 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    if (latch_item) begin
      cur_ent   <= new_ent;
      cur_write <= req.access_write;
    end
    if (res_load) begin
      res_slot     <= res_slot_next;
      res_filled   <= res_filled_next;
      res_wb_valid <= res_wb_valid_next;
      res_wb_page  <= res_wb_page_next;
      res_wb_use   <= res_wb_use_next;
      res_wb_dirty <= res_wb_dirty_next;
      res_hit      <= res_hit_next;
      res_frame    <= res_frame_next;
      res_fault    <= res_fault_next;
    end
  end

  assign rsp.valid              = res_valid;
  assign rsp.slot               = res_slot;
  assign rsp.filled_invalid     = res_filled;
  assign rsp.writeback_valid    = res_wb_valid;
  assign rsp.writeback_page     = res_wb_page;
  assign rsp.writeback_use      = res_wb_use;
  assign rsp.writeback_dirty    = res_wb_dirty;
  assign rsp.hit                = res_hit;
  assign rsp.hit_frame          = res_frame;
  assign rsp.write_fault        = res_fault;
  assign rsp.miss_count         = refill_total;
  assign rsp.invalid_fill_count = empty_fill_total;
  assign rsp.replace_count      = eviction_total;

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (state == ST_IDLE))
    else $error("ready raised while a word is in progress");

  a_evict_only_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVICT) |-> (&slot_valid))
    else $error("eviction with a free slot available");

  a_count_balance: assert property (@(posedge clk) disable iff (rst)
    refill_total == COUNT_W'(empty_fill_total + eviction_total))
    else $error("refill count differs from fill plus replace counts");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (state == ST_IDLE) && res_valid)
    else $error("response load did not return to idle");

  a_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((slot_valid & $past(slot_valid)) == $past(slot_valid)))
    else $error("slot valid bit cleared outside reset");

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  import tlbr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS   = DEF_TLB_ENTRIES;
  localparam int VP_W     = DEF_VPAGE_BITS;
  localparam int PF_W     = DEF_PFRAME_BITS;
  localparam int NUM_DIR  = 21;
  localparam int NUM_RAND = 600;

  typedef struct packed {
    logic            kind;
    logic [VP_W-1:0] vpage;
    logic [PF_W-1:0] frame;
    logic            ro;
    logic            use_bit;
    logic            dirty;
    logic            wr;
  } tlb_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               filled_invalid;
    logic               wb_valid;
    logic [VP_W-1:0]    wb_page;
    logic               wb_use;
    logic               wb_dirty;
    logic               hit;
    logic [PF_W-1:0]    hit_frame;
    logic               write_fault;
    logic [COUNT_W-1:0] misses;
    logic [COUNT_W-1:0] inv_fills;
    logic [COUNT_W-1:0] replaces;
  } tlb_result_t;

  typedef struct packed {
    logic        typed;
    tlb_word_t   word;
    tlb_result_t result;
  } stim_row_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_MASK
  } ready_mode_t;

  // typed rows carry the result straight from a freshly reset buffer
  localparam stim_row_t DIR_TAB [NUM_DIR] = '{
    '{1'b1, '{KIND_REFILL, 20'h00000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
      '{slot: 2'd0, filled_invalid: 1'b1, misses: 32'd1, inv_fills: 32'd1, default: '0}},
    '{1'b1, '{KIND_REFILL, 20'hFFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
      '{slot: 2'd1, filled_invalid: 1'b1, misses: 32'd2, inv_fills: 32'd2, default: '0}},
    '{1'b1, '{KIND_ACCESS, 20'h00000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
      '{slot: 2'd0, hit: 1'b1, hit_frame: 16'h0000, misses: 32'd2, inv_fills: 32'd2,
        default: '0}},
    '{1'b1, '{KIND_ACCESS, 20'hFFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1},
      '{slot: 2'd1, hit: 1'b1, hit_frame: 16'hFFFF, write_fault: 1'b1, misses: 32'd2,
        inv_fills: 32'd2, default: '0}},
    '{1'b1, '{KIND_ACCESS, 20'h12345, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1},
      '{misses: 32'd2, inv_fills: 32'd2, default: '0}},
    '{1'b0, '{KIND_REFILL, 20'h00000, 16'h1234, 1'b0, 1'b0, 1'b0, 1'b0}, '0},
    '{1'b0, '{KIND_ACCESS, 20'h00000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1}, '0},
    '{1'b0, '{KIND_REFILL, 20'hABCDE, 16'h5555, 1'b0, 1'b0, 1'b1, 1'b0}, '0},
    '{1'b0, '{KIND_REFILL, 20'h00001, 16'hAAAA, 1'b1, 1'b0, 1'b0, 1'b0}, '0},
    '{1'b0, '{KIND_ACCESS, 20'h00000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0}, '0},
    '{1'b0, '{KIND_REFILL, 20'h7FFFF, 16'h8000, 1'b0, 1'b1, 1'b0, 1'b1}, '0},
    '{1'b0, '{KIND_ACCESS, 20'h00001, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1}, '0},
    '{1'b0, '{KIND_REFILL, 20'h80000, 16'h7FFF, 1'b0, 1'b0, 1'b0, 1'b0}, '0},
    '{1'b0, '{KIND_ACCESS, 20'hABCDE, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1}, '0},
    '{1'b0, '{KIND_REFILL, 20'h55555, 16'h0001, 1'b1, 1'b1, 1'b1, 1'b0}, '0},
    '{1'b0, '{KIND_REFILL, 20'hAAAAA, 16'hFFFE, 1'b0, 1'b1, 1'b1, 1'b0}, '0},
    '{1'b0, '{KIND_ACCESS, 20'h80000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0}, '0},
    '{1'b0, '{KIND_ACCESS, 20'h00000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0}, '0},
    '{1'b0, '{KIND_ACCESS, 20'hFFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0}, '0},
    '{1'b0, '{KIND_ACCESS, 20'h7FFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1}, '0},
    '{1'b0, '{KIND_REFILL, 20'h00002, 16'h0F0F, 1'b0, 1'b0, 1'b0, 1'b0}, '0}
  };

  logic clk = 1'b0;
  logic rst;

  tlbr_req_if req ();
  tlbr_rsp_if rsp ();

  tlb_refill_replacement dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #6 clk = ~clk;

  // shadow TLB
  logic               ent_valid [NSLOTS];
  logic [VP_W-1:0]    ent_page  [NSLOTS];
  logic [PF_W-1:0]    ent_frame [NSLOTS];
  logic               ent_ro    [NSLOTS];
  logic               ent_use   [NSLOTS];
  logic               ent_dirty [NSLOTS];
  int                 rr_ptr;
  logic [COUNT_W-1:0] refills;
  logic [COUNT_W-1:0] empty_fills;
  logic [COUNT_W-1:0] evictions;

  tlb_result_t pending_results [$];
  int          mismatch_count;
  int          result_idx;
  int          burst_left;

  function automatic tlb_result_t predict_tlb(tlb_word_t w);
    tlb_result_t r;
    int          victim;
    logic        found;
    r      = '0;
    victim = -1;
    found  = 1'b0;
    if (w.kind == KIND_REFILL) begin
      for (int i = 0; i < NSLOTS; i++) begin
        if (!ent_valid[i] && victim < 0) victim = i;
      end
      refills++;
      if (victim >= 0) begin
        empty_fills++;
        r.filled_invalid = 1'b1;
      end else begin
        victim = rr_ptr;
        rr_ptr = (rr_ptr + 1) % NSLOTS;
        evictions++;
        r.wb_valid = 1'b1;
        r.wb_page  = ent_page[victim];
        r.wb_use   = ent_use[victim];
        r.wb_dirty = ent_dirty[victim];
      end
      ent_valid[victim] = 1'b1;
      ent_page[victim]  = w.vpage;
      ent_frame[victim] = w.frame;
      ent_ro[victim]    = w.ro;
      ent_use[victim]   = w.use_bit;
      ent_dirty[victim] = w.dirty;
      r.slot = SLOT_W'(victim);
    end else begin
      for (int i = 0; i < NSLOTS; i++) begin
        if (!found && ent_valid[i] && ent_page[i] == w.vpage) begin
          found       = 1'b1;
          r.slot      = SLOT_W'(i);
          r.hit       = 1'b1;
          r.hit_frame = ent_frame[i];
          ent_use[i]  = 1'b1;
          if (w.wr) begin
            if (ent_ro[i]) r.write_fault = 1'b1;
            else ent_dirty[i] = 1'b1;
          end
        end
      end
    end
    r.misses    = refills;
    r.inv_fills = empty_fills;
    r.replaces  = evictions;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t word %0d: %s", $realtime, result_idx, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // burst/gap shaping on the request side, then one word held until taken
  task automatic send_word(tlb_word_t w, logic typed, tlb_result_t typed_res);
    tlb_result_t res;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req.valid           <= 1'b1;
    req.kind            <= w.kind;
    req.virtual_page    <= w.vpage;
    req.physical_page   <= w.frame;
    req.entry_read_only <= w.ro;
    req.entry_use       <= w.use_bit;
    req.entry_dirty     <= w.dirty;
    req.access_write    <= w.wr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    res = predict_tlb(w);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  always @(posedge clk) begin
    tlb_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no word outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("slot", rsp.slot, want.slot);
        check_field("filled_invalid", rsp.filled_invalid, want.filled_invalid);
        check_field("writeback_valid", rsp.writeback_valid, want.wb_valid);
        check_field("writeback_page", rsp.writeback_page, want.wb_page);
        check_field("writeback_use", rsp.writeback_use, want.wb_use);
        check_field("writeback_dirty", rsp.writeback_dirty, want.wb_dirty);
        check_field("hit", rsp.hit, want.hit);
        check_field("hit_frame", rsp.hit_frame, want.hit_frame);
        check_field("write_fault", rsp.write_fault, want.write_fault);
        check_field("miss_count", rsp.miss_count, want.misses);
        check_field("invalid_fill_count", rsp.invalid_fill_count, want.inv_fills);
        check_field("replace_count", rsp.replace_count, want.replaces);
      end
      result_idx++;
    end
  end

  ready_mode_t stall_mode  = RDY_ALWAYS;
  logic [7:0]  stall_mask  = '1;
  logic [2:0]  stall_phase = '0;
  int          stall_len   = 0;

  always @(posedge clk) begin
    if (stall_len == 0) begin
      stall_mode = ready_mode_t'($urandom_range(0, 3));
      stall_mask = 8'($urandom);
      stall_len  = $urandom_range(8, 64);
    end
    stall_len--;
    stall_phase++;
    case (stall_mode)
      RDY_ALWAYS: rsp.ready <= 1'b1;
      RDY_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
      default:    rsp.ready <= stall_mask[stall_phase];
    endcase
  end

  initial begin
    logic [VP_W-1:0] page_pool [8];
    tlb_word_t       w;
    int              k;
    rst                 <= 1'b1;
    req.valid           <= 1'b0;
    req.kind            <= KIND_REFILL;
    req.virtual_page    <= '0;
    req.physical_page   <= '0;
    req.entry_read_only <= 1'b0;
    req.entry_use       <= 1'b0;
    req.entry_dirty     <= 1'b0;
    req.access_write    <= 1'b0;
    for (int i = 0; i < NSLOTS; i++) ent_valid[i] = 1'b0;
    rr_ptr         = 0;
    refills        = '0;
    empty_fills    = '0;
    evictions      = '0;
    mismatch_count = 0;
    result_idx     = 0;
    burst_left     = 0;
    for (int i = 0; i < 8; i++) page_pool[i] = VP_W'($urandom);
    page_pool[0] = '0;
    page_pool[1] = '1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIR; i++) begin
      send_word(DIR_TAB[i].word, DIR_TAB[i].typed, DIR_TAB[i].result);
    end

    // small page pool keeps hits, duplicates and evictions of known pages common
    for (int n = 0; n < NUM_RAND; n++) begin
      if ($urandom_range(0, 31) == 0) page_pool[$urandom_range(2, 7)] = VP_W'($urandom);
      k         = $urandom_range(0, 7);
      w.kind    = $urandom_range(0, 1) ? KIND_ACCESS : KIND_REFILL;
      w.vpage   = ($urandom_range(0, 3) != 0) ? page_pool[k] : VP_W'($urandom);
      w.frame   = PF_W'($urandom);
      w.ro      = 1'($urandom_range(0, 1));
      w.use_bit = 1'($urandom_range(0, 1));
      w.dirty   = 1'($urandom_range(0, 1));
      w.wr      = 1'($urandom_range(0, 1));
      send_word(w, 1'b0, '0);
    end
    req.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout, %0d words still outstanding", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
